[design/jtl_pkg.sv]
// jtl_pkg: shared types, constants and character helpers for the JSON token lexer.
// Used by jtl_core, jtl_out_queue and json_token_lexer; depends on nothing.

package jtl_pkg;

    // Offsets and document limit
    localparam int unsigned POS_W         = 17;
    localparam int unsigned MAX_DOC_BYTES = 65536;

    // Result queue
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QCNT_W = 3;

    // Stream widths
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 40;

    typedef enum logic [3:0] {
        TK_LBRACE   = 4'd0,
        TK_RBRACE   = 4'd1,
        TK_LBRACKET = 4'd2,
        TK_RBRACKET = 4'd3,
        TK_COMMA    = 4'd4,
        TK_COLON    = 4'd5,
        TK_STRING   = 4'd6,
        TK_NUMBER   = 4'd7,
        TK_TRUE     = 4'd8,
        TK_FALSE    = 4'd9,
        TK_NULL     = 4'd10,
        TK_EOF      = 4'd11,
        TK_ERROR    = 4'd12
    } t_tok_kind;

    typedef enum logic [1:0] {
        LIT_TRUE  = 2'd0,
        LIT_FALSE = 2'd1,
        LIT_NULL  = 2'd2
    } t_lit;

    typedef struct packed {
        t_tok_kind        kind;
        logic [POS_W-1:0] start_ofs;
        logic [POS_W-1:0] end_ofs;
        logic             last;
    } t_token;

    // Results of one processed item, at most two
    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
    } t_step;

    // Character codes
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_VT       = 8'h0B;
    localparam logic [7:0] CH_FF       = 8'h0C;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_0        = 8'h30;
    localparam logic [7:0] CH_9        = 8'h39;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_UA       = 8'h41;
    localparam logic [7:0] CH_UF       = 8'h46;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_A        = 8'h61;
    localparam logic [7:0] CH_B        = 8'h62;
    localparam logic [7:0] CH_E        = 8'h65;
    localparam logic [7:0] CH_F        = 8'h66;
    localparam logic [7:0] CH_L        = 8'h6C;
    localparam logic [7:0] CH_N        = 8'h6E;
    localparam logic [7:0] CH_R        = 8'h72;
    localparam logic [7:0] CH_S        = 8'h73;
    localparam logic [7:0] CH_T        = 8'h74;
    localparam logic [7:0] CH_U        = 8'h75;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= CH_A) && (c <= CH_F)) || ((c >= CH_UA) && (c <= CH_UF));
    endfunction

    // Remaining characters of a literal after its first letter
    function automatic logic [7:0] tail_char(input t_lit sel, input logic [2:0] idx);
        logic [7:0] ch;
        ch = CH_NUL;
        case (sel)
            LIT_TRUE: begin
                case (idx)
                    3'd0: ch = CH_R;
                    3'd1: ch = CH_U;
                    3'd2: ch = CH_E;
                    default: ch = CH_NUL;
                endcase
            end
            LIT_FALSE: begin
                case (idx)
                    3'd0: ch = CH_A;
                    3'd1: ch = CH_L;
                    3'd2: ch = CH_S;
                    3'd3: ch = CH_E;
                    default: ch = CH_NUL;
                endcase
            end
            LIT_NULL: begin
                case (idx)
                    3'd0: ch = CH_U;
                    3'd1: ch = CH_L;
                    3'd2: ch = CH_L;
                    default: ch = CH_NUL;
                endcase
            end
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] tail_len(input t_lit sel);
        return (sel == LIT_FALSE) ? 3'd4 : 3'd3;
    endfunction

    function automatic t_token mk_tok(input t_tok_kind kind, input logic [POS_W-1:0] s,
                                      input logic [POS_W-1:0] e);
        t_token t;
        t.kind      = kind;
        t.start_ofs = s;
        t.end_ofs   = e;
        t.last      = 1'b0;
        return t;
    endfunction

endpackage

[design/jtl_core.sv]
// jtl_core: input register, lexer state and the single-pass step logic.
// Depends on jtl_pkg; hands up to two tokens per item to jtl_out_queue.

module jtl_core
    import jtl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    input  logic                  s_axis_tlast,
    input  logic                  i_room,
    output t_step                 o_step
);

    typedef enum logic [3:0] {
        M_IDLE  = 4'd0,
        M_STR   = 4'd1,
        M_ESC   = 4'd2,
        M_HEX   = 4'd3,
        M_TRUE  = 4'd4,
        M_FALSE = 4'd5,
        M_NULL  = 4'd6,
        M_MINUS = 4'd7,
        M_NUM   = 4'd8
    } t_lex_mode;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_end;

    t_lex_mode        r_mode, n_mode;
    logic [2:0]       r_sub, n_sub;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_tb, n_tb;
    logic             r_halt, n_halt;

    logic             fire;
    logic             s_acc;
    logic [7:0]       c;
    logic             fin;
    logic [POS_W-1:0] p1;

    // idle-mode decode of the current byte
    logic             id_put;
    t_token           id_tok;
    t_lex_mode        id_mode;
    logic [POS_W-1:0] id_tb;
    logic             id_sub_clr;
    logic             id_halt;

    // literal matching
    t_lit             lit_sel;
    t_tok_kind        lit_kind;
    logic             lit_ok;
    logic [2:0]       sub_inc;
    logic [2:0]       sub_dec;

    logic [1:0]       cnt;
    t_token           tok0, tok1;

    assign fire          = r_in_valid && i_room;
    assign s_axis_tready = !r_in_valid || i_room;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    assign c   = r_in_end ? CH_NUL : r_in_byte;
    assign fin = (c == CH_NUL);
    assign p1  = r_pos + POS_W'(1);

    always_comb begin
        id_put     = 1'b0;
        id_tok     = mk_tok(TK_EOF, r_pos, p1);
        id_mode    = M_IDLE;
        id_tb      = r_pos;
        id_sub_clr = 1'b0;
        id_halt    = 1'b0;
        case (c) inside
            CH_NUL: begin
                id_put = 1'b1;
            end
            CH_LBRACE: begin
                id_put = 1'b1; id_tok.kind = TK_LBRACE; id_tb = p1;
            end
            CH_RBRACE: begin
                id_put = 1'b1; id_tok.kind = TK_RBRACE; id_tb = p1;
            end
            CH_LBRACKET: begin
                id_put = 1'b1; id_tok.kind = TK_LBRACKET; id_tb = p1;
            end
            CH_RBRACKET: begin
                id_put = 1'b1; id_tok.kind = TK_RBRACKET; id_tb = p1;
            end
            CH_COMMA: begin
                id_put = 1'b1; id_tok.kind = TK_COMMA; id_tb = p1;
            end
            CH_COLON: begin
                id_put = 1'b1; id_tok.kind = TK_COLON; id_tb = p1;
            end
            CH_QUOTE: begin
                id_mode = M_STR; id_tb = p1;
            end
            CH_T: begin
                id_mode = M_TRUE; id_sub_clr = 1'b1;
            end
            CH_F: begin
                id_mode = M_FALSE; id_sub_clr = 1'b1;
            end
            CH_N: begin
                id_mode = M_NULL; id_sub_clr = 1'b1;
            end
            CH_MINUS: begin
                id_mode = M_MINUS;
            end
            CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_SPACE: begin
                id_tb = p1;
            end
            [CH_0:CH_9]: begin
                id_mode = M_NUM;
            end
            default: begin
                id_put = 1'b1; id_tok.kind = TK_ERROR; id_halt = 1'b1;
            end
        endcase
    end

    always_comb begin
        unique case (r_mode)
            M_FALSE: begin lit_sel = LIT_FALSE; lit_kind = TK_FALSE; end
            M_NULL:  begin lit_sel = LIT_NULL;  lit_kind = TK_NULL;  end
            default: begin lit_sel = LIT_TRUE;  lit_kind = TK_TRUE;  end
        endcase
    end

    assign lit_ok  = (r_sub < tail_len(lit_sel)) && (c == tail_char(lit_sel, r_sub));
    assign sub_inc = r_sub + 3'd1;
    assign sub_dec = r_sub - 3'd1;

    always_comb begin
        n_mode = r_mode;
        n_sub  = r_sub;
        n_pos  = r_pos;
        n_tb   = r_tb;
        n_halt = r_halt;
        cnt    = 2'd0;
        tok0   = mk_tok(TK_ERROR, r_tb, p1);
        tok1   = id_tok;

        if (r_halt) begin
            // drop data bytes until the end of the document
        end else if (!fin && (r_pos >= POS_W'(MAX_DOC_BYTES))) begin
            cnt    = 2'd1;
            tok0   = mk_tok(TK_ERROR, r_tb, r_pos);
            n_halt = 1'b1;
        end else begin
            n_pos = p1;
            unique case (r_mode)
                M_STR: begin
                    if (fin) begin
                        cnt = 2'd1; n_halt = 1'b1;
                    end else if (c == CH_BSLASH) begin
                        n_mode = M_ESC;
                    end else if (c == CH_QUOTE) begin
                        cnt    = 2'd1;
                        tok0   = mk_tok(TK_STRING, r_tb, r_pos);
                        n_tb   = p1;
                        n_mode = M_IDLE;
                    end
                end
                M_ESC: begin
                    if ((c == CH_QUOTE) || (c == CH_BSLASH) || (c == CH_SLASH) ||
                        (c == CH_B) || (c == CH_F) || (c == CH_N) || (c == CH_R) ||
                        (c == CH_T)) begin
                        n_mode = M_STR;
                    end else if (c == CH_U) begin
                        n_mode = M_HEX;
                        n_sub  = 3'd4;
                    end else begin
                        cnt = 2'd1; n_halt = 1'b1;
                    end
                end
                M_HEX: begin
                    if (is_hex(c)) begin
                        n_sub = sub_dec;
                        if (sub_dec == 3'd0) begin
                            n_mode = M_STR;
                        end
                    end else begin
                        cnt = 2'd1; n_halt = 1'b1;
                    end
                end
                M_TRUE, M_FALSE, M_NULL: begin
                    if (lit_ok) begin
                        n_sub = sub_inc;
                        if (sub_inc >= tail_len(lit_sel)) begin
                            cnt    = 2'd1;
                            tok0   = mk_tok(lit_kind, r_tb, p1);
                            n_tb   = p1;
                            n_mode = M_IDLE;
                            n_sub  = 3'd0;
                        end
                    end else begin
                        cnt = 2'd1; n_halt = 1'b1;
                    end
                end
                M_MINUS: begin
                    if (is_digit(c)) begin
                        n_mode = M_NUM;
                    end else begin
                        cnt = 2'd1; tok0 = mk_tok(TK_ERROR, r_tb, r_pos); n_halt = 1'b1;
                    end
                end
                M_NUM: begin
                    // the terminating byte is lexed again from idle
                    if (!is_digit(c) && (c != CH_DOT)) begin
                        tok0   = mk_tok(TK_NUMBER, r_tb, r_pos);
                        cnt    = id_put ? 2'd2 : 2'd1;
                        n_mode = id_mode;
                        n_tb   = id_tb;
                        n_halt = id_halt;
                        if (id_sub_clr) begin
                            n_sub = 3'd0;
                        end
                    end
                end
                default: begin
                    tok0   = id_tok;
                    cnt    = id_put ? 2'd1 : 2'd0;
                    n_mode = id_mode;
                    n_tb   = id_tb;
                    n_halt = id_halt;
                    if (id_sub_clr) begin
                        n_sub = 3'd0;
                    end
                end
            endcase
        end

        // end of document: re-arm
        if (fin) begin
            n_mode = M_IDLE;
            n_sub  = 3'd0;
            n_pos  = '0;
            n_tb   = '0;
            n_halt = 1'b0;
        end

        tok0.last = (cnt == 2'd1);
        tok1.last = 1'b1;
    end

    assign o_step.count = fire ? cnt : 2'd0;
    assign o_step.tok0  = tok0;
    assign o_step.tok1  = tok1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= M_IDLE;
            r_sub      <= 3'd0;
            r_pos      <= '0;
            r_tb       <= '0;
            r_halt     <= 1'b0;
        end else begin
            if (s_acc) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_mode <= n_mode;
                r_sub  <= n_sub;
                r_pos  <= n_pos;
                r_tb   <= n_tb;
                r_halt <= n_halt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_in_byte <= s_axis_tdata;
            r_in_end  <= s_axis_tlast;
        end
    end

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_halt) |-> (o_step.count == 2'd0))
        else $error("halted lexer produced a token");

    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && fin) |=> ((r_pos == '0) && !r_halt && (r_mode == M_IDLE)))
        else $error("lexer not re-armed after end of document");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(MAX_DOC_BYTES))
        else $error("byte position beyond document limit");

endmodule

[design/jtl_out_queue.sv]
// jtl_out_queue: shifting result queue that takes up to two tokens per cycle while it has room for two.
// Depends on jtl_pkg; drains one token per transaction towards the output.

module jtl_out_queue
    import jtl_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_step  i_push,
    output logic   o_room,
    output logic   o_valid,
    input  logic   i_ready,
    output t_token o_head
);

    t_token            r_q [QDEPTH];
    t_token            n_q [QDEPTH];
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic [QCNT_W-1:0] cnt_p;
    logic              pop;

    assign o_valid = (r_cnt != '0);
    assign o_head  = r_q[0];
    assign o_room  = (r_cnt <= QCNT_W'(QDEPTH - 2));
    assign pop     = o_valid && i_ready;
    assign cnt_p   = r_cnt - QCNT_W'(pop);
    assign n_cnt   = cnt_p + QCNT_W'(i_push.count);

    always_comb begin
        for (int i = 0; i < QDEPTH; i++) begin
            n_q[i] = r_q[i];
        end
        if (pop) begin
            for (int i = 0; i < QDEPTH - 1; i++) begin
                n_q[i] = r_q[i + 1];
            end
        end
        for (int i = 0; i < QDEPTH; i++) begin
            if ((i_push.count != 2'd0) && (cnt_p == QCNT_W'(i))) begin
                n_q[i] = i_push.tok0;
            end
            if ((i_push.count == 2'd2) && ((cnt_p + QCNT_W'(1)) == QCNT_W'(i))) begin
                n_q[i] = i_push.tok1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> o_room)
        else $error("token pushed without room");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

endmodule

[design/json_token_lexer.sv]
// json_token_lexer: top level of the streaming JSON tokenizer.
// Depends on jtl_pkg, jtl_core and jtl_out_queue.
//
// Usage
//   Input stream (s_axis_*): one document byte per transaction in tdata. tlast
//   marks the end of a document; its tdata is ignored. A zero byte also ends
//   the document. After every end the lexer re-arms for the next document.
//   Output stream (m_axis_*): one token per transaction. tdata carries kind,
//   start offset and exclusive end offset; tlast flags the final token caused
//   by one input byte (a byte yields zero, one or two tokens).
//   A byte waits in the input register; its tokens then enter the result queue.
//   Throughput: the step logic handles one byte per cycle while the queue has
//   room, and the four-entry result queue drains one token per cycle while
//   m_axis_tready is high, so bytes yielding two tokens (a number closed by
//   punctuation or the end) stall input only once the queue holds over two tokens.
//   An error token halts the lexer: data bytes are swallowed without output
//   until the end of the document.
//   Reset: i_rst_n low at a clock edge clears the input register, the lexer
//   state and the queue; s_axis_tready is high straight after.
//   Receiver stall: tokens are held in the queue; when it has fewer than two
//   free entries the input register holds and s_axis_tready drops.

module json_token_lexer
    import jtl_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic                   s_axis_tlast,   // end_of_input
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [3:0] token_kind, [20:4] token_start,
                                                   // [37:21] token_end, [39:38] zero
    output logic                   m_axis_tlast    // last_of_run
);

    t_step  step;
    logic   room;
    t_token head;

    // Lexer: input register plus the per-byte step
    jtl_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_room        (room),
        .o_step        (step)
    );

    // Result queue: decouples output stalls from the input side
    jtl_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_head  (head)
    );

    // Pack the token, padding to whole bytes
    assign m_axis_tdata = {2'b00, head.end_ofs, head.start_ofs, head.kind};
    assign m_axis_tlast = head.last;

endmodule

[dv/tb_json_token_lexer.sv]
// tb_json_token_lexer: self-checking testbench for the streaming JSON token lexer.
// Holds its own lexer model, a directed table, two full-length documents and random
// documents; depends on jtl_pkg and json_token_lexer only.

module tb_json_token_lexer;
    timeunit 1ns;
    timeprecision 1ps;

    import jtl_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 8;
    localparam int RANDOM_ITEMS   = 1950;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_REPORTS    = 10;
    localparam int RUN_LIMIT_NS   = 50_000_000;

    // Lexer modes of the model; a literal keeps its letter index in lit_idx
    typedef enum logic [2:0] {
        LX_IDLE,
        LX_STR,
        LX_ESC,
        LX_HEX,
        LX_LIT,
        LX_MINUS,
        LX_NUM
    } t_lx_mode;

    // One row of the directed table: n < 0 means the model supplies the tokens
    typedef struct {
        logic [7:0] data;
        logic       mark;
        int         n;
        t_token     t0;
        t_token     t1;
    } t_stim_row;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;      // [7:0] data_byte
    logic                   s_axis_tlast  = 1'b0;    // end_of_input
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;            // [3:0] kind, [20:4] start,
                                                     // [37:21] end, [39:38] zero
    logic                   m_axis_tlast;            // last_of_run

    // Model state
    t_lx_mode    lx_mode    = LX_IDLE;
    t_lit        lit_sel    = LIT_TRUE;
    int          lit_idx    = 0;
    int          hex_left   = 0;
    int unsigned doc_pos    = 0;
    int unsigned tok_origin = 0;
    bit          lx_halted  = 1'b0;

    t_token      step_toks[$];       // tokens caused by the byte being lexed
    t_token      pending_tokens[$];  // tokens still to come out of the block
    t_stim_row   dir_rows[$];
    logic [7:0]  doc_bytes[$];

    int mismatches  = 0;
    int live_items  = 0;
    int tx_calm     = 0;
    bit rx_hold_req = 1'b0;

    logic [7:0] ws_set [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
    string      hex_digits = "0123456789abcdefABCDEF";
    string      esc_chars  = "\"\\/bfnrt";

    json_token_lexer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Lexer model
    // ------------------------------------------------------------------

    function automatic t_token tk(t_tok_kind k, int unsigned s, int unsigned e, bit l);
        t_token t;
        t.kind      = k;
        t.start_ofs = s[POS_W-1:0];
        t.end_ofs   = e[POS_W-1:0];
        t.last      = l;
        return t;
    endfunction

    function automatic void emit(t_tok_kind k, int unsigned s, int unsigned e);
        step_toks.push_back(tk(k, s, e, 1'b0));
    endfunction

    // Emit an error and swallow everything up to the end of the document
    function automatic void lex_error(int unsigned s, int unsigned e);
        emit(TK_ERROR, s, e);
        lx_halted = 1'b1;
    endfunction

    function automatic void lex_rearm();
        lx_mode    = LX_IDLE;
        lit_idx    = 0;
        hex_left   = 0;
        doc_pos    = 0;
        tok_origin = 0;
        lx_halted  = 1'b0;
    endfunction

    function automatic bit is_dec(logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic bit is_hexd(logic [7:0] c);
        return is_dec(c) || (c >= CH_A && c <= CH_F) || (c >= CH_UA && c <= CH_UF);
    endfunction

    // Byte seen between tokens: punctuation, whitespace or the first byte of a token
    function automatic void lex_idle(logic [7:0] c, int unsigned p);
        tok_origin = p;
        case (c)
            CH_NUL: begin
                emit(TK_EOF, p, p + 1);
                return;
            end
            CH_LBRACE:   emit(TK_LBRACE, p, p + 1);
            CH_RBRACE:   emit(TK_RBRACE, p, p + 1);
            CH_LBRACKET: emit(TK_LBRACKET, p, p + 1);
            CH_RBRACKET: emit(TK_RBRACKET, p, p + 1);
            CH_COMMA:    emit(TK_COMMA, p, p + 1);
            CH_COLON:    emit(TK_COLON, p, p + 1);
            CH_QUOTE:    lx_mode = LX_STR;
            CH_T, CH_F, CH_N: begin
                lx_mode = LX_LIT;
                lit_idx = 0;
                lit_sel = (c == CH_T) ? LIT_TRUE : (c == CH_F) ? LIT_FALSE : LIT_NULL;
                return;
            end
            CH_MINUS: begin
                lx_mode = LX_MINUS;
                return;
            end
            CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: ;
            default: begin
                if (is_dec(c)) begin
                    lx_mode = LX_NUM;
                end else begin
                    lex_error(p, p + 1);
                end
                return;
            end
        endcase
        tok_origin = p + 1;
    endfunction

    // Match the letters after the first one of true, false or null
    function automatic void lex_literal(logic [7:0] c, int unsigned p);
        string     tail;
        t_tok_kind kind;
        case (lit_sel)
            LIT_TRUE: begin
                tail = "rue";
                kind = TK_TRUE;
            end
            LIT_FALSE: begin
                tail = "alse";
                kind = TK_FALSE;
            end
            default: begin
                tail = "ull";
                kind = TK_NULL;
            end
        endcase
        if (lit_idx < tail.len() && c == tail[lit_idx]) begin
            lit_idx++;
            if (lit_idx >= tail.len()) begin
                emit(kind, tok_origin, p + 1);
                tok_origin = p + 1;
                lx_mode    = LX_IDLE;
                lit_idx    = 0;
            end
        end else begin
            lex_error(tok_origin, p + 1);
        end
    endfunction

    // Lex one accepted transaction; the tokens it causes end up in step_toks
    function automatic void lex_byte(logic [7:0] data, logic mark);
        logic [7:0]  c;
        bit          fin;
        int unsigned p;
        t_token      t;
        c   = mark ? CH_NUL : data;
        fin = (c == CH_NUL);
        p   = doc_pos;
        step_toks.delete();
        if (lx_halted) begin
            if (fin) lex_rearm();
            return;
        end
        if (!fin && p >= MAX_DOC_BYTES) begin
            lex_error(tok_origin, p);
        end else begin
            case (lx_mode)
                LX_STR: begin
                    if (c == CH_NUL) begin
                        lex_error(tok_origin, p + 1);
                    end else if (c == CH_BSLASH) begin
                        lx_mode = LX_ESC;
                    end else if (c == CH_QUOTE) begin
                        emit(TK_STRING, tok_origin, p);
                        tok_origin = p + 1;
                        lx_mode    = LX_IDLE;
                    end
                end
                LX_ESC: begin
                    case (c)
                        CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T:
                            lx_mode = LX_STR;
                        CH_U: begin
                            lx_mode  = LX_HEX;
                            hex_left = 4;
                        end
                        default: lex_error(tok_origin, p + 1);
                    endcase
                end
                LX_HEX: begin
                    if (is_hexd(c)) begin
                        hex_left--;
                        if (hex_left == 0) lx_mode = LX_STR;
                    end else begin
                        lex_error(tok_origin, p + 1);
                    end
                end
                LX_LIT: lex_literal(c, p);
                LX_MINUS: begin
                    // a lone minus spans itself only, reported on the byte after it
                    if (is_dec(c)) lx_mode = LX_NUM;
                    else lex_error(tok_origin, p);
                end
                LX_NUM: begin
                    // the byte that closes a number is lexed again as a fresh byte
                    if (!is_dec(c) && c != CH_DOT) begin
                        emit(TK_NUMBER, tok_origin, p);
                        lx_mode = LX_IDLE;
                        lex_idle(c, p);
                    end
                end
                default: lex_idle(c, p);
            endcase
            doc_pos = p + 1;
        end
        if (fin) lex_rearm();
        if (step_toks.size() > 0) begin
            t      = step_toks.pop_back();
            t.last = 1'b1;
            step_toks.push_back(t);
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Mostly no gap, sometimes a short one, rarely a long one
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Sender gaps, with calm stretches where every cycle carries a byte
    function automatic int next_tx_gap();
        if (tx_calm > 0) begin
            tx_calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) tx_calm = $urandom_range(20, 100);
        return draw_gap();
    endfunction

    // Offer one transaction, hold it until accepted, then idle for the requested gap.
    // with_model: queue the model's tokens; clear it where the caller queued its own.
    task automatic send_item(logic [7:0] data, logic mark, bit with_model, int gap);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= mark;
        do @(posedge i_clk); while (!s_axis_tready);
        lex_byte(data, mark);
        if (with_model) begin
            foreach (step_toks[i]) pending_tokens.push_back(step_toks[i]);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    function automatic void row(logic [7:0] data, logic mark, int n, t_token t0, t_token t1);
        t_stim_row r;
        r.data = data;
        r.mark = mark;
        r.n    = n;
        r.t0   = t0;
        r.t1   = t1;
        dir_rows.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Random documents
    // ------------------------------------------------------------------

    function automatic logic [7:0] ws_byte();
        return ws_set[$urandom_range(0, 5)];
    endfunction

    // Append one byte, now and then swapped for an arbitrary nonzero one
    function automatic void add_byte(logic [7:0] b);
        if ($urandom_range(0, 49) == 0) doc_bytes.push_back(8'($urandom_range(1, 255)));
        else doc_bytes.push_back(b);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endfunction

    function automatic void add_string();
        logic [7:0] b;
        int         r;
        add_byte(CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
            r = $urandom_range(0, 9);
            if (r < 6) begin
                do b = 8'($urandom_range(32, 126)); while (b == CH_QUOTE || b == CH_BSLASH);
                add_byte(b);
            end else if (r < 7) begin
                add_byte(8'($urandom_range(128, 255)));
            end else begin
                add_byte(CH_BSLASH);
                if ($urandom_range(0, 2) == 0) begin
                    add_byte(CH_U);
                    repeat (4) add_byte(hex_digits[$urandom_range(0, 21)]);
                end else begin
                    add_byte(esc_chars[$urandom_range(0, 7)]);
                end
            end
        end
        add_byte(CH_QUOTE);
    endfunction

    function automatic void add_number();
        if ($urandom_range(0, 2) == 0) add_byte(CH_MINUS);
        add_byte(8'(CH_0 + $urandom_range(0, 9)));
        repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 3) == 0) add_byte(CH_DOT);
            else add_byte(8'(CH_0 + $urandom_range(0, 9)));
        end
    endfunction

    // Malformed fragments: stray byte, cut or misspelt literal, bad escape, lone minus
    function automatic void add_broken();
        case ($urandom_range(0, 5))
            0: add_byte(8'($urandom_range(1, 255)));
            1: add_text("tr");
            2: add_text("fals0");
            3: add_text("\"\\q");
            4: add_text("\"\\u0g");
            default: add_text("- ");
        endcase
    endfunction

    function automatic void add_part();
        case ($urandom_range(0, 13))
            0: add_byte(CH_LBRACE);
            1: add_byte(CH_RBRACE);
            2: add_byte(CH_LBRACKET);
            3: add_byte(CH_RBRACKET);
            4: add_byte(CH_COMMA);
            5: add_byte(CH_COLON);
            6, 7: add_string();
            8, 9, 13: add_number();
            10: begin
                case ($urandom_range(0, 2))
                    0: add_text("true");
                    1: add_text("false");
                    default: add_text("null");
                endcase
            end
            11: repeat ($urandom_range(1, 3)) add_byte(ws_byte());
            default: add_broken();
        endcase
    endfunction

    // Build a short document, send it and close it with an end mark or a zero byte.
    // Bytes swallowed after an error do not count as live items.
    task automatic send_random_doc();
        doc_bytes.delete();
        repeat ($urandom_range(1, 20)) begin
            add_part();
            if ($urandom_range(0, 1) == 0) add_byte(ws_byte());
        end
        // now and then end the document inside a token
        case ($urandom_range(0, 9))
            0: add_text("\"");
            1: add_text("\"\\");
            2: add_text("-");
            3: add_text("fa");
            4: add_text("\"\\u1");
            default: ;
        endcase
        foreach (doc_bytes[i]) begin
            if (!lx_halted) live_items++;
            send_item(doc_bytes[i], 1'b0, 1'b1, next_tx_gap());
        end
        if (!lx_halted) live_items++;
        if ($urandom_range(0, 2) == 0) send_item(CH_NUL, 1'b0, 1'b1, next_tx_gap());
        else send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1, next_tx_gap());
    endtask

    // Full-length document: whitespace with a comma now and then. Without overrun it
    // ends in a digit so the end mark at offset MAX_DOC_BYTES gives a number and eof at
    // the top of the offset range; with overrun a literal runs past the limit.
    task automatic send_big_doc(bit overrun);
        logic [7:0] b;
        for (int p = 0; p < MAX_DOC_BYTES; p++) begin
            b = (p % 97 == 96) ? CH_COMMA : ws_byte();
            if (!overrun && p == MAX_DOC_BYTES - 1) b = CH_0 + 8'd7;
            if (overrun && p == MAX_DOC_BYTES - 2) b = CH_T;
            if (overrun && p == MAX_DOC_BYTES - 1) b = CH_R;
            send_item(b, 1'b0, 1'b1, 0);
        end
        if (overrun) begin
            send_item(CH_U, 1'b0, 1'b1, 0);
            send_item(CH_E, 1'b0, 1'b1, 0);
            send_item(CH_NUL, 1'b0, 1'b1, next_tx_gap());
        end else begin
            send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1, next_tx_gap());
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial begin
        t_token none;
        none = '0;

        // Object with an escaped string, a number closed by punctuation, null, and a
        // number left open at the end mark
        row(CH_LBRACE,    1'b0, 1, tk(TK_LBRACE, 0, 1, 1'b1), none);
        row(CH_QUOTE,     1'b0, -1, none, none);
        row(CH_BSLASH,    1'b0, -1, none, none);
        row(CH_U,         1'b0, -1, none, none);
        row(CH_UF,        1'b0, -1, none, none);
        row(CH_0,         1'b0, -1, none, none);
        row(CH_A,         1'b0, -1, none, none);
        row(CH_9,         1'b0, -1, none, none);
        row(CH_QUOTE,     1'b0, -1, none, none);
        row(CH_COLON,     1'b0, -1, none, none);
        row(CH_MINUS,     1'b0, -1, none, none);
        row(CH_0 + 8'd7,  1'b0, -1, none, none);
        row(CH_DOT,       1'b0, -1, none, none);
        row(CH_RBRACKET,  1'b0, -1, none, none);
        row(CH_N,         1'b0, -1, none, none);
        row(CH_U,         1'b0, -1, none, none);
        row(CH_L,         1'b0, -1, none, none);
        row(CH_L,         1'b0, -1, none, none);
        row(CH_0 + 8'd5,  1'b0, -1, none, none);
        row(8'h00,        1'b1, 2, tk(TK_NUMBER, 18, 19, 1'b0), tk(TK_EOF, 19, 20, 1'b1));
        // Zero byte inside a string: error instead of eof, then re-armed
        row(CH_QUOTE,     1'b0, -1, none, none);
        row(CH_NUL,       1'b0, 1, tk(TK_ERROR, 1, 2, 1'b1), none);
        // Lone minus halts; the brace is swallowed; the end mark re-arms silently
        row(CH_MINUS,     1'b0, -1, none, none);
        row(CH_COMMA,     1'b0, 1, tk(TK_ERROR, 0, 1, 1'b1), none);
        row(CH_RBRACE,    1'b0, -1, none, none);
        row(8'hFF,        1'b1, -1, none, none);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Queue typed tokens ahead of the transaction: they must precede its results
        foreach (dir_rows[i]) begin
            if (dir_rows[i].n >= 1) pending_tokens.push_back(dir_rows[i].t0);
            if (dir_rows[i].n >= 2) pending_tokens.push_back(dir_rows[i].t1);
            send_item(dir_rows[i].data, dir_rows[i].mark, dir_rows[i].n < 0, next_tx_gap());
        end

        send_big_doc(1'b0);
        send_big_doc(1'b1);

        // Stall the receiver for a long stretch while bytes keep coming
        rx_hold_req = 1'b1;
        while (live_items < RANDOM_ITEMS) send_random_doc();

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Receiver: random stalls with calm stretches, plus one long hold on request
    initial begin
        int rx_stall;
        int rx_calm;
        rx_stall = 0;
        rx_calm  = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end else if (rx_stall > 0) begin
                m_axis_tready <= 1'b0;
                rx_stall--;
            end else begin
                m_axis_tready <= 1'b1;
                if (rx_calm > 0) begin
                    rx_calm--;
                end else begin
                    rx_stall = draw_gap();
                    if ($urandom_range(0, 39) == 0) rx_calm = $urandom_range(20, 100);
                end
            end
        end
    end

    // Report as kind/start/end/last; only the first few are printed
    function automatic void log_mismatch(bit have_want, t_token want, t_token got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            if (have_want) begin
                $display("%0t: token mismatch, want %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                         $time, want.kind, want.start_ofs, want.end_ofs, want.last,
                         got.kind, got.start_ofs, got.end_ofs, got.last);
            end else begin
                $display("%0t: unexpected token %0d/%0d/%0d/%0b", $time,
                         got.kind, got.start_ofs, got.end_ofs, got.last);
            end
        end
    endfunction

    // Compare every accepted token with the oldest one outstanding
    always @(posedge i_clk) begin
        t_token got;
        t_token want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind      = t_tok_kind'(m_axis_tdata[3:0]);
            got.start_ofs = m_axis_tdata[20:4];
            got.end_ofs   = m_axis_tdata[37:21];
            got.last      = m_axis_tlast;
            if (pending_tokens.size() == 0) begin
                log_mismatch(1'b0, got, got);
            end else begin
                want = pending_tokens.pop_front();
                if (want !== got || m_axis_tdata[39:38] !== 2'b00) log_mismatch(1'b1, want, got);
            end
        end
    end

    // Watchdog: give up well past the slowest legal run
    initial begin
        #RUN_LIMIT_NS;
        $display("simulation failed");
        $finish;
    end

endmodule
